FILE: hdl/rlrf_pkg.sv
// ----------------------------------------------------------------------------
// rlrf_pkg: shared types, constants and helpers of the robust range filter
// Fixed-point constants, command and status types between controller and
// datapath, and small arithmetic helpers used by the datapath.
// ----------------------------------------------------------------------------
package rlrf_pkg;

    // input and output range format
    localparam int RANGE_FRAC_BITS = 16;

    // register indexes of the configuration port
    localparam logic [1:0] REG_SLOW_RATE    = 2'd0;
    localparam logic [1:0] REG_FAST_RATE    = 2'd1;
    localparam logic [1:0] REG_CUSUM_OFFSET = 2'd2;
    localparam logic [1:0] REG_CUSUM_LIMIT  = 2'd3;

    // register reset values
    localparam logic [16:0] SLOW_RATE_RST    = 17'd6554;
    localparam logic [16:0] FAST_RATE_RST    = 17'd32768;
    localparam logic [23:0] CUSUM_OFFSET_RST = 24'd32768;
    localparam logic [23:0] CUSUM_LIMIT_RST  = 24'd262144;

    // fixed-point constants
    localparam logic signed [17:0] HUBER_K      = 18'sd88146;
    localparam logic [16:0]        MAD_SCALE    = 17'd97164;
    localparam logic [23:0]        SPREAD_FLOOR = 24'd7;
    localparam logic signed [31:0] LN2_Q30      = 32'sd744261118;
    localparam logic signed [31:0] INV_LN2_Q30  = 32'sd1549082005;
    localparam logic signed [63:0] LOG_MAX      = 64'sd8388607;
    localparam logic signed [63:0] LOG_MIN      = -64'sd8388608;
    localparam logic signed [63:0] Q8_MAX       = 64'sd16777215;
    localparam logic [40:0]        E_MAX        = 41'd2147483647;
    localparam logic signed [63:0] EXP_HI       = 64'sd1572864;
    localparam logic signed [63:0] EXP_LO       = -64'sd4194304;

    // smallest accepted range, one micro unit, at least one lsb
    localparam longint TR_FLOOR_RAW = ((64'd1 << RANGE_FRAC_BITS) + 500000) / 1000000;
    localparam logic [31:0] TR_FLOOR = (TR_FLOOR_RAW == 0) ? 32'd1 : 32'(TR_FLOOR_RAW);

    // iteration counts
    localparam int LN_STEPS  = 16;
    localparam int EXP_STEPS = 16;
    localparam int DIV_STEPS = 41;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_LN_SQ,
        OP_LN_MUL,
        OP_LN_RND,
        OP_SEED,
        OP_DIV_E,
        OP_DIV_STEP,
        OP_RISE,
        OP_MU,
        OP_MU_RND,
        OP_PEAK,
        OP_FALL,
        OP_LEVEL,
        OP_TGT,
        OP_SMUL,
        OP_SPR,
        OP_CORR,
        OP_Z,
        OP_EMUL,
        OP_ERND,
        OP_ESTEP,
        OP_EFIN,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] step;
        logic       pass;
    } t_cmd;

    typedef struct packed {
        logic seeded;
        logic elev;
        logic down;
    } t_stat;

    typedef logic [EXP_STEPS-1:0][31:0] t_root_tab;

    // floor square root, bit by bit
    function automatic logic [63:0] f_isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = v;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // factors 2^(2^-j) in Q1.30, in the order the exp steps use them
    function automatic t_root_tab f_root_tab();
        t_root_tab   tab;
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int i = 0; i < EXP_STEPS; i++) begin
            r = f_isqrt64(r << 30);
            tab[i] = r[31:0];
        end
        return tab;
    endfunction

    localparam t_root_tab EXP_ROOT = f_root_tab();

    // shift right with rounding half away from zero
    function automatic logic signed [63:0] f_rnd_shr(input logic signed [63:0] v,
                                                     input int unsigned sh);
        logic [63:0] mag;
        logic [63:0] half;
        half = 64'd1 << (sh - 1);
        mag  = v[63] ? 64'(-v) : 64'(v);
        mag  = (mag + half) >> sh;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

    // one cusum step, saturating to the unsigned 32 bit range
    function automatic logic [31:0] f_cusum(input logic [31:0] sum,
                                            input logic signed [32:0] add,
                                            input logic [23:0] offs);
        logic signed [34:0] s;
        s = $signed({3'b000, sum}) + 35'(add) - $signed({11'd0, offs});
        if (s[34]) begin
            return '0;
        end else if (s[33:32] != 2'b00) begin
            return '1;
        end
        return s[31:0];
    endfunction

endpackage

FILE: hdl/rlrf_if.sv
// ----------------------------------------------------------------------------
// rlrf_if: channel interfaces of the robust range filter
// Valid/ready channels for range requests, results and register writes.
// ----------------------------------------------------------------------------
interface rlrf_tr_if;
    logic        valid;
    logic        ready;
    logic [31:0] true_range;
    modport source (output valid, output true_range, input ready);
    modport sink (input valid, input true_range, output ready);
endinterface

interface rlrf_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] robust_range;
    logic [31:0] level_value;
    logic [23:0] spread_value;
    logic        fast_tracked;
    logic        elevated;
    modport source (output valid, output robust_range, output level_value,
                    output spread_value, output fast_tracked, output elevated,
                    input ready);
    modport sink (input valid, input robust_range, input level_value,
                  input spread_value, input fast_tracked, input elevated,
                  output ready);
endinterface

interface rlrf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/rlrf_dp.sv
// ----------------------------------------------------------------------------
// rlrf_dp: datapath of the robust range filter
// Filter state, configuration registers, log/exp iteration registers, a
// bit-serial divider and the shared product register, driven by commands.
// ----------------------------------------------------------------------------
module rlrf_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rlrf_pkg::t_cmd       i_cmd,
    input  logic [31:0]          i_tr,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [23:0]          i_cfg_data,
    output rlrf_pkg::t_stat      o_stat,
    output logic [31:0]          o_robust_range,
    output logic [31:0]          o_level_value,
    output logic [23:0]          o_spread_value,
    output logic                 o_fast_tracked,
    output logic                 o_elevated
);

    // configuration
    logic [16:0]        r_slow;
    logic [16:0]        r_fast;
    logic [23:0]        r_offs;
    logic [23:0]        r_lim;

    // filter state
    logic signed [23:0] r_level;
    logic [23:0]        r_spread;
    logic [31:0]        r_rise;
    logic [31:0]        r_fall;
    logic signed [23:0] r_peak;
    logic               r_elev;
    logic               r_seeded;
    logic               r_up;
    logic               r_down;

    // working registers
    logic [30:0]        r_m;
    logic [4:0]         r_k;
    logic [15:0]        r_frac;
    logic signed [63:0] r_prod;
    logic signed [23:0] r_logtr;
    logic [23:0]        r_sfs;
    logic [40:0]        r_num;
    logic [24:0]        r_rem;
    logic               r_neg;
    logic signed [42:0] r_p1;
    logic signed [23:0] r_mu;
    logic signed [27:0] r_sdiff;
    logic signed [23:0] r_z24;
    logic               r_ehi;
    logic               r_elo;
    logic signed [7:0]  r_n;
    logic [15:0]        r_f;
    logic [31:0]        r_em;
    logic [31:0]        r_rr;
    logic [31:0]        r_lvx;

    // result registers
    logic [31:0]        r_o_rr;
    logic [31:0]        r_o_lv;
    logic [23:0]        r_o_spread;
    logic               r_o_fast;
    logic               r_o_elev;

    // log front end: floor, leading one, normalize
    logic [31:0]        x_tr;
    logic [4:0]         lead;
    logic [61:0]        norm;
    logic [61:0]        sq;
    logic signed [6:0]  sk;
    logic signed [22:0] l2;
    logic signed [53:0] ln_p;

    always_comb begin
        x_tr = (i_tr > rlrf_pkg::TR_FLOOR) ? i_tr : rlrf_pkg::TR_FLOOR;
        lead = '0;
        for (int i = 0; i < 32; i++) begin
            if (x_tr[i]) begin
                lead = 5'(i);
            end
        end
        norm = {x_tr, 30'd0} >> lead;
        sq   = r_m * r_m;
        sk   = $signed({2'b00, r_k}) - 7'(rlrf_pkg::RANGE_FRAC_BITS);
        l2   = {sk, r_frac};
        ln_p = l2 * rlrf_pkg::LN2_Q30;
    end

    // divider setup and step
    logic [23:0]        sfs_n;
    logic signed [23:0] peak_n;
    logic signed [25:0] ddiff;
    logic [24:0]        dmag;
    logic [40:0]        dnum;
    logic [24:0]        rsh;
    logic               ge;
    logic [30:0]        qc;
    logic signed [31:0] e_val;

    always_comb begin
        sfs_n  = (r_spread > rlrf_pkg::SPREAD_FLOOR) ? r_spread : rlrf_pkg::SPREAD_FLOOR;
        peak_n = (r_mu > r_peak) ? r_mu : r_peak;
        if (i_cmd.op == rlrf_pkg::OP_PEAK) begin
            ddiff = 26'(peak_n) - 26'(r_logtr);
            dnum  = '0;
        end else begin
            ddiff = 26'(r_logtr) - 26'(r_level);
            dnum  = '0;
        end
        dmag = ddiff[25] ? 25'(-ddiff) : 25'(ddiff);
        if (i_cmd.op == rlrf_pkg::OP_PEAK) begin
            dnum = {dmag[24:0], 16'd0} + 41'(r_sfs >> 1);
        end else begin
            dnum = {dmag[24:0], 16'd0} + 41'(sfs_n >> 1);
        end
        rsh   = {r_rem[23:0], r_num[40]};
        ge    = rsh >= {1'b0, r_sfs};
        qc    = (r_num > rlrf_pkg::E_MAX) ? rlrf_pkg::E_MAX[30:0] : r_num[30:0];
        e_val = r_neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    end

    // cusum, huber clip and products
    logic [31:0]        rise_n;
    logic [31:0]        fall_n;
    logic signed [17:0] psi;
    logic [16:0]        rate;
    logic [16:0]        srate;
    logic signed [60:0] mu_p;
    logic signed [45:0] smul_p;
    logic signed [63:0] mu_t;
    logic signed [25:0] dev_s;
    logic [24:0]        dev;
    logic [41:0]        dev_p;
    logic signed [63:0] tgt;
    logic signed [63:0] spr_t;
    logic [47:0]        sq2;

    always_comb begin
        rise_n = rlrf_pkg::f_cusum(r_rise, $signed({2'b00, qc}), r_offs);
        fall_n = rlrf_pkg::f_cusum(r_fall, 33'(e_val), r_offs);
        if (e_val > 32'(rlrf_pkg::HUBER_K)) begin
            psi = rlrf_pkg::HUBER_K;
        end else if (e_val < -32'(rlrf_pkg::HUBER_K)) begin
            psi = -rlrf_pkg::HUBER_K;
        end else begin
            psi = e_val[17:0];
        end
        rate   = (r_up || r_down) ? r_fast : r_slow;
        srate  = r_down ? r_fast : r_slow;
        mu_p   = r_p1 * $signed({1'b0, rate});
        smul_p = r_sdiff * $signed({1'b0, srate});
        mu_t   = 64'(r_level) + rlrf_pkg::f_rnd_shr(r_prod, 32);
        dev_s  = 26'(r_logtr) - 26'(r_level);
        dev    = dev_s[25] ? 25'(-dev_s) : 25'(dev_s);
        dev_p  = dev * rlrf_pkg::MAD_SCALE;
        tgt    = rlrf_pkg::f_rnd_shr(r_prod, 16);
        spr_t  = $signed({40'd0, r_spread}) + rlrf_pkg::f_rnd_shr(r_prod, 16);
        sq2    = r_spread * r_spread;
    end

    // exp: argument, steps, final shift
    logic signed [63:0] z_val;
    logic signed [55:0] ez_p;
    logic signed [63:0] y_val;
    logic [63:0]        em_p;
    logic signed [8:0]  esh;
    logic [8:0]         eamt;
    logic [63:0]        ev;
    logic [31:0]        eres;

    always_comb begin
        if (i_cmd.pass) begin
            z_val = 64'(r_level);
        end else begin
            z_val = 64'(r_level) + rlrf_pkg::f_rnd_shr(r_prod, 17);
        end
        ez_p  = r_z24 * rlrf_pkg::INV_LN2_Q30;
        y_val = rlrf_pkg::f_rnd_shr(r_prod, 30);
        em_p  = r_em * rlrf_pkg::EXP_ROOT[i_cmd.step];
        esh   = 9'(r_n) + 9'(rlrf_pkg::RANGE_FRAC_BITS) - 9'sd30;
        eamt  = 9'(-esh);
        ev    = '0;
        eres  = '0;
        if (r_ehi) begin
            eres = '1;
        end else if (r_elo) begin
            eres = '0;
        end else if (!esh[8]) begin
            if (esh >= 9'sd32) begin
                eres = '1;
            end else begin
                ev   = {32'd0, r_em} << esh[4:0];
                eres = (ev[63:32] != 32'd0) ? '1 : ev[31:0];
            end
        end else if (eamt >= 9'd62) begin
            eres = '0;
        end else begin
            ev   = ({32'd0, r_em} + (64'd1 << (eamt - 9'd1))) >> eamt;
            eres = (ev[63:32] != 32'd0) ? '1 : ev[31:0];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow <= rlrf_pkg::SLOW_RATE_RST;
            r_fast <= rlrf_pkg::FAST_RATE_RST;
            r_offs <= rlrf_pkg::CUSUM_OFFSET_RST;
            r_lim  <= rlrf_pkg::CUSUM_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rlrf_pkg::REG_SLOW_RATE: begin
                    r_slow <= i_cfg_data[16:0];
                end
                rlrf_pkg::REG_FAST_RATE: begin
                    r_fast <= i_cfg_data[16:0];
                end
                rlrf_pkg::REG_CUSUM_OFFSET: begin
                    r_offs <= i_cfg_data;
                end
                rlrf_pkg::REG_CUSUM_LIMIT: begin
                    r_lim <= i_cfg_data;
                end
                default: begin
                    r_lim <= r_lim;
                end
            endcase
        end
    end

    // command execution
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_spread <= '0;
            r_rise   <= '0;
            r_fall   <= '0;
            r_peak   <= '0;
            r_elev   <= 1'b0;
            r_seeded <= 1'b0;
            r_up     <= 1'b0;
            r_down   <= 1'b0;
        end else begin
            case (i_cmd.op)
                rlrf_pkg::OP_LOAD: begin
                    r_m    <= norm[30:0];
                    r_k    <= lead;
                    r_frac <= '0;
                    r_up   <= 1'b0;
                    r_down <= 1'b0;
                end
                rlrf_pkg::OP_LN_SQ: begin
                    r_m    <= sq[61] ? sq[61:31] : sq[60:30];
                    r_frac <= {r_frac[14:0], sq[61]};
                end
                rlrf_pkg::OP_LN_MUL: begin
                    r_prod <= 64'(ln_p);
                end
                rlrf_pkg::OP_LN_RND: begin
                    r_logtr <= 24'(rlrf_pkg::f_rnd_shr(r_prod, 30));
                end
                rlrf_pkg::OP_SEED: begin
                    r_level  <= r_logtr;
                    r_spread <= '0;
                    r_seeded <= 1'b1;
                end
                rlrf_pkg::OP_DIV_E: begin
                    r_sfs <= sfs_n;
                    r_num <= dnum;
                    r_rem <= '0;
                    r_neg <= ddiff[25];
                end
                rlrf_pkg::OP_DIV_STEP: begin
                    r_rem <= ge ? (rsh - {1'b0, r_sfs}) : rsh;
                    r_num <= {r_num[39:0], ge};
                end
                rlrf_pkg::OP_RISE: begin
                    r_rise <= rise_n;
                    r_up   <= rise_n > {8'd0, r_lim};
                    r_p1   <= psi * $signed({1'b0, r_sfs});
                    if ((rise_n > {8'd0, r_lim}) && !r_elev) begin
                        r_elev <= 1'b1;
                        r_peak <= r_level;
                        r_fall <= '0;
                    end
                end
                rlrf_pkg::OP_MU: begin
                    r_prod <= 64'(mu_p);
                end
                rlrf_pkg::OP_MU_RND: begin
                    if (mu_t > rlrf_pkg::LOG_MAX) begin
                        r_mu <= rlrf_pkg::LOG_MAX[23:0];
                    end else if (mu_t < rlrf_pkg::LOG_MIN) begin
                        r_mu <= rlrf_pkg::LOG_MIN[23:0];
                    end else begin
                        r_mu <= mu_t[23:0];
                    end
                end
                rlrf_pkg::OP_PEAK: begin
                    r_peak <= peak_n;
                    r_num  <= dnum;
                    r_rem  <= '0;
                    r_neg  <= ddiff[25];
                end
                rlrf_pkg::OP_FALL: begin
                    if (fall_n > {8'd0, r_lim}) begin
                        r_down <= 1'b1;
                        r_elev <= 1'b0;
                        r_rise <= '0;
                        r_fall <= '0;
                    end else begin
                        r_fall <= fall_n;
                    end
                end
                rlrf_pkg::OP_LEVEL: begin
                    r_level <= r_mu;
                    r_prod  <= $signed({22'd0, dev_p});
                end
                rlrf_pkg::OP_TGT: begin
                    r_sdiff <= 28'(tgt) - $signed({4'd0, r_spread});
                end
                rlrf_pkg::OP_SMUL: begin
                    r_prod <= 64'(smul_p);
                end
                rlrf_pkg::OP_SPR: begin
                    if (spr_t < 0) begin
                        r_spread <= '0;
                    end else if (spr_t > rlrf_pkg::Q8_MAX) begin
                        r_spread <= rlrf_pkg::Q8_MAX[23:0];
                    end else begin
                        r_spread <= spr_t[23:0];
                    end
                end
                rlrf_pkg::OP_CORR: begin
                    r_prod <= $signed({16'd0, sq2});
                end
                rlrf_pkg::OP_Z: begin
                    r_z24 <= z_val[23:0];
                    r_ehi <= z_val >= rlrf_pkg::EXP_HI;
                    r_elo <= z_val <= rlrf_pkg::EXP_LO;
                end
                rlrf_pkg::OP_EMUL: begin
                    r_prod <= 64'(ez_p);
                end
                rlrf_pkg::OP_ERND: begin
                    r_n  <= y_val[23:16];
                    r_f  <= y_val[15:0];
                    r_em <= 32'd1 << 30;
                end
                rlrf_pkg::OP_ESTEP: begin
                    if (r_f[15]) begin
                        r_em <= 32'((em_p + (64'd1 << 29)) >> 30);
                    end
                    r_f <= {r_f[14:0], 1'b0};
                end
                rlrf_pkg::OP_EFIN: begin
                    if (i_cmd.pass) begin
                        r_lvx <= eres;
                    end else begin
                        r_rr <= eres;
                    end
                end
                rlrf_pkg::OP_OUT: begin
                    r_o_rr     <= r_rr;
                    r_o_lv     <= r_lvx;
                    r_o_spread <= r_spread;
                    r_o_fast   <= r_up || r_down;
                    r_o_elev   <= r_elev;
                end
                default: begin
                    r_up <= r_up;
                end
            endcase
        end
    end

    assign o_stat.seeded   = r_seeded;
    assign o_stat.elev     = r_elev;
    assign o_stat.down     = r_down;
    assign o_robust_range  = r_o_rr;
    assign o_level_value   = r_o_lv;
    assign o_spread_value  = r_o_spread;
    assign o_fast_tracked  = r_o_fast;
    assign o_elevated      = r_o_elev;

endmodule

FILE: hdl/rlrf_ctrl.sv
// ----------------------------------------------------------------------------
// rlrf_ctrl: sequencer of the robust range filter
// One-hot state machine that walks the datapath through log, division,
// filter update and the two exp passes, and owns the request handshakes.
// ----------------------------------------------------------------------------
module rlrf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rlrf_pkg::t_stat   i_stat,
    output rlrf_pkg::t_cmd    o_cmd
);

    typedef enum logic [25:0] {
        S_IDLE  = 26'd1 << 0,
        S_LN    = 26'd1 << 1,
        S_LNMUL = 26'd1 << 2,
        S_LNRND = 26'd1 << 3,
        S_SEED  = 26'd1 << 4,
        S_DIVE  = 26'd1 << 5,
        S_DIV1  = 26'd1 << 6,
        S_RISE  = 26'd1 << 7,
        S_MU1   = 26'd1 << 8,
        S_MU1R  = 26'd1 << 9,
        S_PEAK  = 26'd1 << 10,
        S_DIV2  = 26'd1 << 11,
        S_FALL  = 26'd1 << 12,
        S_MU2   = 26'd1 << 13,
        S_MU2R  = 26'd1 << 14,
        S_LEVEL = 26'd1 << 15,
        S_TGT   = 26'd1 << 16,
        S_SMUL  = 26'd1 << 17,
        S_SPR   = 26'd1 << 18,
        S_CORR  = 26'd1 << 19,
        S_Z     = 26'd1 << 20,
        S_EMUL  = 26'd1 << 21,
        S_ERND  = 26'd1 << 22,
        S_ESTEP = 26'd1 << 23,
        S_EFIN  = 26'd1 << 24,
        S_OUT   = 26'd1 << 25
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       r_pass, n_pass;
    logic       r_valid, n_valid;
    rlrf_pkg::t_op op;

    // next state and command
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pass  = r_pass;
        op      = rlrf_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = rlrf_pkg::OP_LOAD;
                    n_cnt   = '0;
                    n_state = S_LN;
                end
            end
            S_LN: begin
                op    = rlrf_pkg::OP_LN_SQ;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(rlrf_pkg::LN_STEPS - 1)) begin
                    n_state = S_LNMUL;
                end
            end
            S_LNMUL: begin
                op      = rlrf_pkg::OP_LN_MUL;
                n_state = S_LNRND;
            end
            S_LNRND: begin
                op      = rlrf_pkg::OP_LN_RND;
                n_state = i_stat.seeded ? S_DIVE : S_SEED;
            end
            S_SEED: begin
                op      = rlrf_pkg::OP_SEED;
                n_state = S_CORR;
            end
            S_DIVE: begin
                op      = rlrf_pkg::OP_DIV_E;
                n_cnt   = '0;
                n_state = S_DIV1;
            end
            S_DIV1: begin
                op    = rlrf_pkg::OP_DIV_STEP;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(rlrf_pkg::DIV_STEPS - 1)) begin
                    n_state = S_RISE;
                end
            end
            S_RISE: begin
                op      = rlrf_pkg::OP_RISE;
                n_state = S_MU1;
            end
            S_MU1: begin
                op      = rlrf_pkg::OP_MU;
                n_state = S_MU1R;
            end
            S_MU1R: begin
                op      = rlrf_pkg::OP_MU_RND;
                n_state = i_stat.elev ? S_PEAK : S_LEVEL;
            end
            S_PEAK: begin
                op      = rlrf_pkg::OP_PEAK;
                n_cnt   = '0;
                n_state = S_DIV2;
            end
            S_DIV2: begin
                op    = rlrf_pkg::OP_DIV_STEP;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(rlrf_pkg::DIV_STEPS - 1)) begin
                    n_state = S_FALL;
                end
            end
            S_FALL: begin
                op      = rlrf_pkg::OP_FALL;
                n_state = S_MU2;
            end
            S_MU2: begin
                // redo the level update at the fast rate on recovery
                if (i_stat.down) begin
                    op      = rlrf_pkg::OP_MU;
                    n_state = S_MU2R;
                end else begin
                    n_state = S_LEVEL;
                end
            end
            S_MU2R: begin
                op      = rlrf_pkg::OP_MU_RND;
                n_state = S_LEVEL;
            end
            S_LEVEL: begin
                op      = rlrf_pkg::OP_LEVEL;
                n_state = S_TGT;
            end
            S_TGT: begin
                op      = rlrf_pkg::OP_TGT;
                n_state = S_SMUL;
            end
            S_SMUL: begin
                op      = rlrf_pkg::OP_SMUL;
                n_state = S_SPR;
            end
            S_SPR: begin
                op      = rlrf_pkg::OP_SPR;
                n_state = S_CORR;
            end
            S_CORR: begin
                op      = rlrf_pkg::OP_CORR;
                n_pass  = 1'b0;
                n_state = S_Z;
            end
            S_Z: begin
                op      = rlrf_pkg::OP_Z;
                n_state = S_EMUL;
            end
            S_EMUL: begin
                op      = rlrf_pkg::OP_EMUL;
                n_state = S_ERND;
            end
            S_ERND: begin
                op      = rlrf_pkg::OP_ERND;
                n_cnt   = '0;
                n_state = S_ESTEP;
            end
            S_ESTEP: begin
                op    = rlrf_pkg::OP_ESTEP;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(rlrf_pkg::EXP_STEPS - 1)) begin
                    n_state = S_EFIN;
                end
            end
            S_EFIN: begin
                op = rlrf_pkg::OP_EFIN;
                if (r_pass) begin
                    n_state = S_OUT;
                end else begin
                    n_pass  = 1'b1;
                    n_state = S_Z;
                end
            end
            S_OUT: begin
                // wait for the result register to drain
                if (!r_valid || i_out_ready) begin
                    op      = rlrf_pkg::OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        if (op == rlrf_pkg::OP_OUT) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pass  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pass  <= n_pass;
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_valid;
    assign o_cmd.op    = op;
    assign o_cmd.step  = r_cnt[3:0];
    assign o_cmd.pass  = r_pass;

endmodule

FILE: hdl/robust_log_range_filter_core.sv
// ----------------------------------------------------------------------------
// robust_log_range_filter_core: robust log-domain average of bar ranges
// Top level joining the sequencer and the datapath to the channel ports.
// ----------------------------------------------------------------------------
// Usage:
//   i_tr carries one request per bar: the true range, unsigned Q16.16.
//   o_res returns exactly one result per request: the corrected and plain
//   back-transformed level, the spread, the fast-tracking and elevated flags.
//   i_cfg writes the four rate and cusum registers; ready is always high,
//   writes are meant for times when no request is in flight.
// Throughput:
//   one request at a time. The 41-step bit-serial divider (twice per
//   request while elevated, once otherwise, not on the first request),
//   the 16 squaring steps of the log and the 16 root-multiply steps of
//   each of the two exp passes set the processing time of a request.
// Reset:
//   synchronous, active low; registers return to their defaults and the
//   filter returns to unseeded, so the next request seeds the level.
// Stall:
//   a finished result waits in the output register; the next request is
//   accepted and worked on meanwhile, and holds at its last step until the
//   previous result is taken.
// ----------------------------------------------------------------------------
module robust_log_range_filter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rlrf_tr_if.sink     i_tr,
    rlrf_res_if.source  o_res,
    rlrf_cfg_if.sink    i_cfg
);

    rlrf_pkg::t_cmd  cmd;
    rlrf_pkg::t_stat stat;

    // sequencer
    rlrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_tr.valid),
        .o_in_ready  (i_tr.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath
    rlrf_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_tr           (i_tr.true_range),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_stat         (stat),
        .o_robust_range (o_res.robust_range),
        .o_level_value  (o_res.level_value),
        .o_spread_value (o_res.spread_value),
        .o_fast_tracked (o_res.fast_tracked),
        .o_elevated     (o_res.elevated)
    );

    // register writes are always taken
    assign i_cfg.ready = 1'b1;

endmodule

FILE: hdl/rlrf_chk.sv
// ----------------------------------------------------------------------------
// rlrf_chk: port checker of the robust range filter
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module rlrf_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_robust_range,
    input logic [31:0] i_level_value,
    input logic [23:0] i_spread_value
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        ($stable(i_robust_range) && $stable(i_level_value) && $stable(i_spread_value)))
        else $error("result payload changed while stalled");

    // one request at a time: an accepted request closes the input
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted while busy");

    // no result appears right after a request is taken
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result without processing time");

    // reset clears the result channel
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind robust_log_range_filter_core rlrf_chk u_rlrf_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_tr.valid),
    .i_in_ready     (i_tr.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_robust_range (o_res.robust_range),
    .i_level_value  (o_res.level_value),
    .i_spread_value (o_res.spread_value)
);
